FILE: rtl/core/tnt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tnt_pkg: shared types and widths
// Beat types, job type and derived arithmetic widths for the normal and
// tangent unit.
// ----------------------------------------------------------------------------
package tnt_pkg;

  localparam int COORD_WIDTH   = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int OUT_WIDTH     = 16;

  localparam int EDGE_WIDTH = COORD_WIDTH + 1;
  localparam int COMP_WIDTH = 2 * EDGE_WIDTH + 1;
  localparam int PROD_WIDTH = 2 * COMP_WIDTH;
  localparam int SQ_WIDTH   = 2 * COMP_WIDTH - 1;
  localparam int SUM_WIDTH  = SQ_WIDTH + 2;
  localparam int Q_WIDTH    = OUT_FRAC_BITS + 1;
  localparam int ACC_WIDTH  = SUM_WIDTH + 2 * Q_WIDTH + 2;
  localparam int BIT_WIDTH  = $clog2(Q_WIDTH);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic signed [COORD_WIDTH-1:0] tex_u;
    logic signed [COORD_WIDTH-1:0] tex_v;
  } in_beat_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] normal_x;
    logic signed [OUT_WIDTH-1:0] normal_y;
    logic signed [OUT_WIDTH-1:0] normal_z;
    logic signed [OUT_WIDTH-1:0] tangent_x;
    logic signed [OUT_WIDTH-1:0] tangent_y;
    logic signed [OUT_WIDTH-1:0] tangent_z;
    logic                        normal_valid;
    logic                        tangent_valid;
  } out_beat_t;

  typedef struct packed {
    logic signed [EDGE_WIDTH-1:0] e1x;
    logic signed [EDGE_WIDTH-1:0] e1y;
    logic signed [EDGE_WIDTH-1:0] e1z;
    logic signed [EDGE_WIDTH-1:0] e2x;
    logic signed [EDGE_WIDTH-1:0] e2y;
    logic signed [EDGE_WIDTH-1:0] e2z;
    logic signed [EDGE_WIDTH-1:0] d1u;
    logic signed [EDGE_WIDTH-1:0] d1v;
    logic signed [EDGE_WIDTH-1:0] d2u;
    logic signed [EDGE_WIDTH-1:0] d2v;
  } job_t;

endpackage
`default_nettype wire

FILE: rtl/core/tnt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tnt_front: corner collector
// Holds the first two corners of a triangle and, on the third, forms the
// edge and texture deltas and pushes them as one job.
// ----------------------------------------------------------------------------
module tnt_front import tnt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_beat_t in_data,
  output logic          job_push,
  input  wire logic     job_full,
  output job_t          job
);

  logic [1:0] corner_count;
  in_beat_t   held0;
  in_beat_t   held1;
  logic       accept;

  function automatic logic signed [EDGE_WIDTH-1:0] diff(
    input logic signed [COORD_WIDTH-1:0] a,
    input logic signed [COORD_WIDTH-1:0] b
  );
    return EDGE_WIDTH'(a) - EDGE_WIDTH'(b);
  endfunction

  assign in_stall = (corner_count == 2'd2) && job_full;
  assign accept   = in_valid && !in_stall;
  assign job_push = accept && (corner_count == 2'd2);

  always_comb begin
    job.e1x = diff(held1.pos_x, held0.pos_x);
    job.e1y = diff(held1.pos_y, held0.pos_y);
    job.e1z = diff(held1.pos_z, held0.pos_z);
    job.e2x = diff(in_data.pos_x, held0.pos_x);
    job.e2y = diff(in_data.pos_y, held0.pos_y);
    job.e2z = diff(in_data.pos_z, held0.pos_z);
    job.d1u = diff(held1.tex_u, held0.tex_u);
    job.d1v = diff(held1.tex_v, held0.tex_v);
    job.d2u = diff(in_data.tex_u, held0.tex_u);
    job.d2v = diff(in_data.tex_v, held0.tex_v);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      case (corner_count)
        2'd0: held0 <= in_data;
        2'd1: held1 <= in_data;
        default: ;
      endcase
    end
    if (rst) begin
      corner_count <= 2'd0;
    end else if (accept) begin
      case (corner_count)
        2'd0:    corner_count <= 2'd1;
        2'd1:    corner_count <= 2'd2;
        default: corner_count <= 2'd0;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/tnt_job_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tnt_job_queue: two-entry job queue
// Decouples the corner collector from the arithmetic back end.
// ----------------------------------------------------------------------------
module tnt_job_queue import tnt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_data,
  output logic      full,
  output logic      valid,
  input  wire logic pop,
  output job_t      pop_data
);

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full     = (count == 2'd2);
  assign valid    = (count != 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/tnt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tnt_back: normal and tangent arithmetic
// A shared registered multiplier forms the cross product, determinant,
// tangent vector and squares; a three-lane bit-serial unit then finds each
// unit component exactly; the result waits in an output register.
// ----------------------------------------------------------------------------
module tnt_back import tnt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  output logic      job_pop,
  input  wire job_t job_in,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_beat_t out_data
);

  typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_SUM, ST_DIV, ST_DONE} state_t;

  localparam int LAST_STEP = 19;

  state_t state;
  job_t   job;
  logic [4:0] cnt;

  logic signed [COMP_WIDTH-1:0] vec [7];
  logic        [SQ_WIDTH-1:0]   sq  [6];
  logic signed [PROD_WIDTH-1:0] prod;
  logic signed [COMP_WIDTH-1:0] op_a;
  logic signed [COMP_WIDTH-1:0] op_b;
  logic [4:0] acc_step;
  logic [2:0] vec_idx;
  logic [2:0] sq_idx;

  logic [SUM_WIDTH-1:0] sum_g;
  logic                 nvalid;
  logic                 tvalid;

  logic                 phase;
  logic [BIT_WIDTH-1:0] bitc;
  logic [ACC_WIDTH-1:0] s2;
  logic [ACC_WIDTH-1:0] acc_a [3];
  logic [ACC_WIDTH-1:0] acc_b [3];
  logic [Q_WIDTH-1:0]   q     [3];
  logic [Q_WIDTH-1:0]   nq    [3];
  logic [ACC_WIDTH-1:0] trial [3];
  logic [ACC_WIDTH-1:0] tgt   [3];
  logic                 fits  [3];
  out_beat_t            result;

  function automatic logic signed [COMP_WIDTH-1:0] sx(input logic signed [EDGE_WIDTH-1:0] v);
    return COMP_WIDTH'(v);
  endfunction

  function automatic logic signed [OUT_WIDTH-1:0] mk(
    input logic [Q_WIDTH-1:0] mag, input logic neg, input logic ok
  );
    logic signed [Q_WIDTH:0] v;
    v = $signed({1'b0, mag});
    if (neg) v = -v;
    if (!ok) v = '0;
    return OUT_WIDTH'(v);
  endfunction

  assign job_pop  = (state == ST_IDLE) && job_valid;
  assign acc_step = cnt - 5'd1;
  assign vec_idx  = acc_step[3:1];
  assign sq_idx   = 3'(acc_step - 5'd14);

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cnt)
      5'd0:  begin op_a = sx(job.e1y); op_b = sx(job.e2z); end
      5'd1:  begin op_a = sx(job.e1z); op_b = sx(job.e2y); end
      5'd2:  begin op_a = sx(job.e1z); op_b = sx(job.e2x); end
      5'd3:  begin op_a = sx(job.e1x); op_b = sx(job.e2z); end
      5'd4:  begin op_a = sx(job.e1x); op_b = sx(job.e2y); end
      5'd5:  begin op_a = sx(job.e1y); op_b = sx(job.e2x); end
      5'd6:  begin op_a = sx(job.d1u); op_b = sx(job.d2v); end
      5'd7:  begin op_a = sx(job.d1v); op_b = sx(job.d2u); end
      5'd8:  begin op_a = sx(job.e1x); op_b = sx(job.d2v); end
      5'd9:  begin op_a = sx(job.e2x); op_b = sx(job.d1v); end
      5'd10: begin op_a = sx(job.e1y); op_b = sx(job.d2v); end
      5'd11: begin op_a = sx(job.e2y); op_b = sx(job.d1v); end
      5'd12: begin op_a = sx(job.e1z); op_b = sx(job.d2v); end
      5'd13: begin op_a = sx(job.e2z); op_b = sx(job.d1v); end
      5'd14: begin op_a = vec[0]; op_b = vec[0]; end
      5'd15: begin op_a = vec[1]; op_b = vec[1]; end
      5'd16: begin op_a = vec[2]; op_b = vec[2]; end
      5'd17: begin op_a = vec[4]; op_b = vec[4]; end
      5'd18: begin op_a = vec[5]; op_b = vec[5]; end
      5'd19: begin op_a = vec[6]; op_b = vec[6]; end
      default: ;
    endcase
  end

  // Trial of one more quotient bit: (q + 2^b)^2 * s = A + (B << (b+1)) + (s << 2b),
  // with A = q^2 * s and acc_b holding B << (b+1).
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tgt[i]   = ACC_WIDTH'(phase ? sq[3 + i] : sq[i]) << (2 * OUT_FRAC_BITS);
      trial[i] = acc_a[i] + acc_b[i] + s2;
      fits[i]  = (trial[i] <= tgt[i]);
    end
  end

  always_comb begin
    result.normal_x      = mk(nq[0], vec[0][COMP_WIDTH-1], nvalid);
    result.normal_y      = mk(nq[1], vec[1][COMP_WIDTH-1], nvalid);
    result.normal_z      = mk(nq[2], vec[2][COMP_WIDTH-1], nvalid);
    result.tangent_x     = mk(q[0], vec[4][COMP_WIDTH-1] ^ vec[3][COMP_WIDTH-1], tvalid);
    result.tangent_y     = mk(q[1], vec[5][COMP_WIDTH-1] ^ vec[3][COMP_WIDTH-1], tvalid);
    result.tangent_z     = mk(q[2], vec[6][COMP_WIDTH-1] ^ vec[3][COMP_WIDTH-1], tvalid);
    result.normal_valid  = nvalid;
    result.tangent_valid = tvalid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
      phase     <= 1'b0;
      bitc      <= '0;
    end else begin
      // A beat taken while a new one is loaded is handled in ST_DONE.
      if (out_valid && !out_stall && (state != ST_DONE)) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            job   <= job_in;
            cnt   <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (cnt <= 5'(LAST_STEP)) prod <= op_a * op_b;
          if (cnt != 5'd0) begin
            if (acc_step < 5'd14) begin
              if (!acc_step[0]) vec[vec_idx] <= prod[COMP_WIDTH-1:0];
              else              vec[vec_idx] <= vec[vec_idx] - prod[COMP_WIDTH-1:0];
            end else begin
              sq[sq_idx] <= prod[SQ_WIDTH-1:0];
            end
          end
          if (cnt == 5'(LAST_STEP + 1)) state <= ST_SUM;
          cnt <= cnt + 5'd1;
        end
        ST_SUM: begin
          sum_g <= SUM_WIDTH'(sq[3]) + SUM_WIDTH'(sq[4]) + SUM_WIDTH'(sq[5]);
          nvalid <= ((sq[0] | sq[1] | sq[2]) != '0);
          tvalid <= (vec[3] != '0) && ((sq[3] | sq[4] | sq[5]) != '0);
          s2 <= ACC_WIDTH'(SUM_WIDTH'(sq[0]) + SUM_WIDTH'(sq[1]) + SUM_WIDTH'(sq[2]))
                << (2 * OUT_FRAC_BITS);
          for (int i = 0; i < 3; i++) begin
            acc_a[i] <= '0;
            acc_b[i] <= '0;
            q[i]     <= '0;
          end
          phase <= 1'b0;
          bitc  <= BIT_WIDTH'(OUT_FRAC_BITS);
          state <= ST_DIV;
        end
        ST_DIV: begin
          if ((bitc == '0) && !phase) begin
            for (int i = 0; i < 3; i++) begin
              nq[i]    <= fits[i] ? (q[i] | Q_WIDTH'(1)) : q[i];
              acc_a[i] <= '0;
              acc_b[i] <= '0;
              q[i]     <= '0;
            end
            s2    <= ACC_WIDTH'(sum_g) << (2 * OUT_FRAC_BITS);
            bitc  <= BIT_WIDTH'(OUT_FRAC_BITS);
            phase <= 1'b1;
          end else begin
            for (int i = 0; i < 3; i++) begin
              if (fits[i]) begin
                acc_a[i]   <= trial[i];
                acc_b[i]   <= (acc_b[i] >> 1) + s2;
                q[i][bitc] <= 1'b1;
              end else begin
                acc_b[i] <= acc_b[i] >> 1;
              end
            end
            s2   <= s2 >> 2;
            bitc <= bitc - BIT_WIDTH'(1);
            if (bitc == '0) state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_data  <= result;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/triangle_normal_tangent_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_normal_tangent_unit: face normal and tangent of triangles
// Takes one corner per beat and returns one normal and tangent beat for every
// third corner.
// ----------------------------------------------------------------------------
// Corners are taken one per cycle, but a third corner stalls while the queue is
// full; the first two of a triangle are only held. The third forms a job that
// waits in a two-entry queue for the back end, which finishes one triangle
// before it takes the next: the shared multiplier forms the cross product,
// determinant, tangent vector and squares, the two norms are summed, and two
// passes through the three-lane bit-serial unit find each unit component
// exactly. Results are Q1.14, truncated toward zero; a degenerate vector gives
// zeros with its valid flag low.
module triangle_normal_tangent_unit import tnt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_beat_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_beat_t     out_data
);

  logic job_push;
  logic job_full;
  logic job_valid;
  logic job_pop;
  job_t job_new;
  job_t job_head;

  tnt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .job_push (job_push),
    .job_full (job_full),
    .job      (job_new)
  );

  tnt_job_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_new),
    .full      (job_full),
    .valid     (job_valid),
    .pop       (job_pop),
    .pop_data  (job_head)
  );

  tnt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job_in    (job_head),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for triangle_normal_tangent_unit
// Feeds triangle corners with random gaps and checks every normal and tangent
// beat against an exact integer predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_top;
  import tnt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;

  // Holds the first two corners of a triangle and the normal/tangent beats
  // still owed by the unit.
  class normal_tangent_board;
    out_beat_t owed[$];
    int errors = 0;
    int corners_held = 0;
    longint held_pos[2][3];
    longint held_tex[2][2];

    // Largest q <= 2^14 with q^2 * s <= c^2 * 2^28, carrying the sign of c.
    function automatic longint unit_component(longint c, logic [127:0] s);
      logic [127:0] mag, target, t;
      longint q;
      mag = 128'((c < 0) ? -c : c);
      target = (mag * mag) << (2 * OUT_FRAC_BITS);
      q = 0;
      for (int b = OUT_FRAC_BITS; b >= 0; b--) begin
        t = 128'(q | (64'd1 << b));
        if (t * t * s <= target) q = 64'(t);
      end
      return (c < 0) ? -q : q;
    endfunction

    function automatic logic [127:0] length_sq(longint v[3]);
      logic [127:0] acc;
      logic [127:0] m;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        m = 128'((v[i] < 0) ? -v[i] : v[i]);
        acc += m * m;
      end
      return acc;
    endfunction

    function void note_corner(in_beat_t b);
      longint p[3], e1[3], e2[3], n[3], g[3];
      longint d1u, d1v, d2u, d2v, det;
      logic [127:0] s;
      out_beat_t r;
      p[0] = b.pos_x;
      p[1] = b.pos_y;
      p[2] = b.pos_z;
      if (corners_held < 2) begin
        held_pos[corners_held] = p;
        held_tex[corners_held][0] = b.tex_u;
        held_tex[corners_held][1] = b.tex_v;
        corners_held++;
        return;
      end
      corners_held = 0;
      for (int i = 0; i < 3; i++) begin
        e1[i] = held_pos[1][i] - held_pos[0][i];
        e2[i] = p[i] - held_pos[0][i];
      end
      d1u = held_tex[1][0] - held_tex[0][0];
      d1v = held_tex[1][1] - held_tex[0][1];
      d2u = longint'(b.tex_u) - held_tex[0][0];
      d2v = longint'(b.tex_v) - held_tex[0][1];
      n[0] = e1[1] * e2[2] - e1[2] * e2[1];
      n[1] = e1[2] * e2[0] - e1[0] * e2[2];
      n[2] = e1[0] * e2[1] - e1[1] * e2[0];
      det = d1u * d2v - d1v * d2u;
      for (int i = 0; i < 3; i++) begin
        g[i] = e1[i] * d2v - e2[i] * d1v;
        if (det < 0) g[i] = -g[i];
      end
      r = '0;
      s = length_sq(n);
      r.normal_valid = (s != 0);
      if (s != 0) begin
        r.normal_x = 16'(unit_component(n[0], s));
        r.normal_y = 16'(unit_component(n[1], s));
        r.normal_z = 16'(unit_component(n[2], s));
      end
      s = length_sq(g);
      r.tangent_valid = (s != 0) && (det != 0);
      if (r.tangent_valid) begin
        r.tangent_x = 16'(unit_component(g[0], s));
        r.tangent_y = 16'(unit_component(g[1], s));
        r.tangent_z = 16'(unit_component(g[2], s));
      end
      owed.push_back(r);
    endfunction

    function void check(out_beat_t got);
      out_beat_t w;
      if (owed.size() == 0) begin
        $error("unexpected result beat %h", got);
        errors++;
        return;
      end
      w = owed.pop_front();
      if (got.normal_x !== w.normal_x) begin
        $error("normal_x: expected %0d, got %0d", w.normal_x, got.normal_x); errors++;
      end
      if (got.normal_y !== w.normal_y) begin
        $error("normal_y: expected %0d, got %0d", w.normal_y, got.normal_y); errors++;
      end
      if (got.normal_z !== w.normal_z) begin
        $error("normal_z: expected %0d, got %0d", w.normal_z, got.normal_z); errors++;
      end
      if (got.tangent_x !== w.tangent_x) begin
        $error("tangent_x: expected %0d, got %0d", w.tangent_x, got.tangent_x); errors++;
      end
      if (got.tangent_y !== w.tangent_y) begin
        $error("tangent_y: expected %0d, got %0d", w.tangent_y, got.tangent_y); errors++;
      end
      if (got.tangent_z !== w.tangent_z) begin
        $error("tangent_z: expected %0d, got %0d", w.tangent_z, got.tangent_z); errors++;
      end
      if (got.normal_valid !== w.normal_valid) begin
        $error("normal_valid: expected %0b, got %0b", w.normal_valid, got.normal_valid);
        errors++;
      end
      if (got.tangent_valid !== w.tangent_valid) begin
        $error("tangent_valid: expected %0b, got %0b", w.tangent_valid, got.tangent_valid);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;
  int        cycles = 0;
  normal_tangent_board board = new();

  triangle_normal_tangent_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver stalls about a quarter of the time, with one quiet window.
  always @(posedge clk) begin
    if (rst || (cycles > 6000 && cycles < 10000)) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 25);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check(out_data);
  end

  task automatic send_corner(in_beat_t b, bit quiet);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 25) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_corner(b);
  endtask

  function automatic in_beat_t corner_of(int x, int y, int z, int u, int v);
    in_beat_t b;
    b.pos_x = 16'(x);
    b.pos_y = 16'(y);
    b.pos_z = 16'(z);
    b.tex_u = 16'(u);
    b.tex_v = 16'(v);
    return b;
  endfunction

  function automatic in_beat_t random_corner();
    return in_beat_t'(80'({$urandom, $urandom, $urandom}));
  endfunction

  task automatic send_triangle(in_beat_t a, in_beat_t b, in_beat_t c, bit quiet);
    send_corner(a, quiet);
    send_corner(b, quiet);
    send_corner(c, quiet);
  endtask

  initial begin
    in_beat_t a, b, c;
    int kind;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Extremes of every field, in both orders.
    send_triangle(corner_of(-32768, -32768, -32768, -32768, -32768),
                  corner_of(32767, -32768, 32767, 32767, -32768),
                  corner_of(-32768, 32767, 32767, -32768, 32767), 0);
    send_triangle(corner_of(32767, 32767, 32767, 32767, 32767),
                  corner_of(-32768, 32767, -32768, -32768, 32767),
                  corner_of(32767, -32768, -32768, 32767, -32768), 0);
    // Simple axis-aligned triangle with a clean UV mapping.
    send_triangle(corner_of(0, 0, 0, 0, 0), corner_of(256, 0, 0, 4096, 0),
                  corner_of(0, 256, 0, 0, 4096), 0);
    // Mirrored UVs give a negative determinant.
    send_triangle(corner_of(0, 0, 0, 0, 0), corner_of(256, 0, 0, 0, 4096),
                  corner_of(0, 256, 0, 4096, 0), 0);
    // Degenerate normal: collinear corners.
    send_triangle(corner_of(0, 0, 0, 0, 0), corner_of(100, 200, 300, 4096, 0),
                  corner_of(200, 400, 600, 0, 4096), 0);
    // Degenerate tangent: zero determinant from identical UVs.
    send_triangle(corner_of(0, 0, 0, 7, 7), corner_of(256, 0, 0, 7, 7),
                  corner_of(0, 256, 0, 7, 7), 0);
    // Nonzero determinant but zero tangent vector: d1v = 0 and e1 = 0.
    send_triangle(corner_of(5, 5, 5, 0, 0), corner_of(5, 5, 5, 4096, 0),
                  corner_of(9, -3, 2, 0, 4096), 0);
    // Everything degenerate at once.
    send_triangle(corner_of(1, 1, 1, 1, 1), corner_of(1, 1, 1, 1, 1),
                  corner_of(1, 1, 1, 1, 1), 0);

    for (int t = 0; t < 350; t++) begin
      kind = $urandom_range(0, 99);
      a = random_corner();
      b = random_corner();
      c = random_corner();
      if (kind < 20) begin
        // Small triangle around a random base.
        b = corner_of(a.pos_x + $signed($urandom_range(0, 64)) - 32,
                      a.pos_y + $signed($urandom_range(0, 64)) - 32,
                      a.pos_z + $signed($urandom_range(0, 64)) - 32,
                      a.tex_u + $signed($urandom_range(0, 64)) - 32,
                      a.tex_v + $signed($urandom_range(0, 64)) - 32);
        c = corner_of(a.pos_x + $signed($urandom_range(0, 64)) - 32,
                      a.pos_y + $signed($urandom_range(0, 64)) - 32,
                      a.pos_z + $signed($urandom_range(0, 64)) - 32,
                      a.tex_u + $signed($urandom_range(0, 64)) - 32,
                      a.tex_v + $signed($urandom_range(0, 64)) - 32);
      end else if (kind < 28) begin
        c.pos_x = b.pos_x;
        c.pos_y = b.pos_y;
        c.pos_z = b.pos_z;
      end else if (kind < 36) begin
        b.tex_u = a.tex_u;
        b.tex_v = a.tex_v;
      end
      if (t == 200) begin
        // Let the unit drain completely before the next triangle.
        in_valid <= 1'b0;
        while (board.owed.size() != 0) @(posedge clk);
      end
      send_triangle(a, b, c, (t >= 100 && t < 160));
    end
    in_valid <= 1'b0;

    while (board.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
